FILE: hw/rtl/obws_pkg.sv
// package with shared constants, types and cordic tables for the wheel speed block
`timescale 1ns / 1ps
`default_nettype none
package obws_pkg;

  localparam int NumStages = 16;
  localparam int NumWheels = 4;
  localparam int NumRegs = 8;
  localparam int AngW = 33;
  localparam int CordW = 20;
  localparam logic signed [CordW-1:0] CordicX0 = 20'sd19898;

  localparam logic [15:0] MountAngle [NumWheels] = '{16'd8192, 16'd24576, 16'd40960, 16'd57344};

  function automatic logic signed [AngW-1:0] atan_turn(input logic [4:0] i);
    logic signed [AngW-1:0] r;
    case (i)
      5'd0: r = 33'sd536870912;
      5'd1: r = 33'sd316933406;
      5'd2: r = 33'sd167458907;
      5'd3: r = 33'sd85004756;
      5'd4: r = 33'sd42667331;
      5'd5: r = 33'sd21354465;
      5'd6: r = 33'sd10680862;
      5'd7: r = 33'sd5340245;
      5'd8: r = 33'sd2670675;
      5'd9: r = 33'sd1335087;
      5'd10: r = 33'sd667544;
      5'd11: r = 33'sd333772;
      5'd12: r = 33'sd166886;
      5'd13: r = 33'sd83443;
      5'd14: r = 33'sd41722;
      5'd15: r = 33'sd20861;
      5'd16: r = 33'sd10430;
      5'd17: r = 33'sd5215;
      5'd18: r = 33'sd2608;
      5'd19: r = 33'sd1304;
      5'd20: r = 33'sd652;
      5'd21: r = 33'sd326;
      5'd22: r = 33'sd163;
      5'd23: r = 33'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // one rotation lane flowing through the cordic chain
  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [AngW-1:0] z;
    logic flip;
  } rot_t;

  // command fields riding alongside the chain
  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] turn_rate;
    logic brake;
  } cmd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/obws_cell.sv
// one cordic micro-rotation cell for five angle lanes plus command side-band
`timescale 1ns / 1ps
`default_nettype none
module obws_cell
  import obws_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic [4:0]  stage,
  input  wire logic        in_valid,
  input  wire rot_t  [NumWheels:0] in_rot,
  input  wire cmd_t        in_cmd,
  output logic             out_valid,
  output rot_t       [NumWheels:0] out_rot,
  output cmd_t             out_cmd
);

  rot_t [NumWheels:0] rot_next;
  logic signed [AngW-1:0] atn;

  assign atn = atan_turn(stage);

  always_comb begin
    for (int l = 0; l <= NumWheels; l++) begin
      rot_next[l].flip = in_rot[l].flip;
      if (!in_rot[l].z[AngW-1]) begin
        rot_next[l].x = in_rot[l].x - (in_rot[l].y >>> stage);
        rot_next[l].y = in_rot[l].y + (in_rot[l].x >>> stage);
        rot_next[l].z = in_rot[l].z - atn;
      end else begin
        rot_next[l].x = in_rot[l].x + (in_rot[l].y >>> stage);
        rot_next[l].y = in_rot[l].y - (in_rot[l].x >>> stage);
        rot_next[l].z = in_rot[l].z + atn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_rot <= rot_next;
      out_cmd <= in_cmd;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/obws_wheel.sv
// per-wheel arithmetic: products, sum, rounding, gain and saturation in registered stages
`timescale 1ns / 1ps
`default_nettype none
module obws_wheel
  import obws_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [CordW-1:0] cos_h,
  input  wire logic signed [CordW-1:0] cos_a,
  input  wire logic signed [CordW-1:0] sin_a,
  input  wire cmd_t               cmd,
  input  wire logic signed [15:0] gain,
  input  wire logic signed [15:0] lever,
  output logic signed [15:0]      speed
);

  logic signed [2*CordW-1:0] sc, cc;
  logic signed [31:0] lw;
  logic signed [15:0] vx1, vy1;
  logic signed [63:0] s;
  logic signed [41:0] s16;
  logic signed [15:0] g2;
  logic signed [63:0] p;
  logic signed [43:0] pr;

  assign pr = 44'((p + 64'sd524288) >>> 20);

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: trig products and lever term
      sc <= sin_a * cos_h;
      cc <= cos_a * cos_h;
      lw <= lever * cmd.turn_rate;
      vx1 <= cmd.vel_x;
      vy1 <= cmd.vel_y;
      // stage 2: sum in 2^-30 units, later rounded to 2^-8
      s <= -(64'(sc) * vx1) + 64'(cc) * vy1 + (64'(lw) <<< 22);
      g2 <= gain;
      // stage 3 on: rounded to 2^-8, scaled by negated gain, then rounded and saturated
      s16 <= 42'((s + 64'sd2097152) >>> 22);
      p <= -(64'(s16) * g2);
      if (pr > 44'sd32767) speed <= 16'sh7fff;
      else if (pr < -44'sd32768) speed <= 16'sh8000;
      else speed <= pr[15:0];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/omni_base_wheel_speeds_top.sv
// top level of the four-wheel omni base wheel speed pipeline
// throughput: one command per cycle; the cordic chain of cells and the
//   per-wheel multiplier stages all advance together
// the whole pipe stalls while a finished result waits on m_axis_tready
// reset (synchronous, active high) clears valids and loads gains 1.0, levers 1.0
`timescale 1ns / 1ps
`default_nettype none
module omni_base_wheel_speeds_top
  import obws_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // heading, vel_x, vel_y, turn_rate
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // wheel1..wheel4 speed
  output logic             m_axis_tuser,   // braked
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_data
);

  // five register stages in each wheel unit
  localparam int TailStages = 5;

  logic signed [15:0] regs [NumRegs];
  logic en;

  // pipe advances unless the output register is held
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NumWheels; k++) begin
        regs[k] <= 16'sd4096;
        regs[NumWheels+k] <= 16'sd256;
      end
    end else if (cfg_we) begin
      regs[cfg_addr] <= cfg_data;
    end
  end

  // input unpack and quadrant fold for heading and four wheel angles
  logic [15:0] hd;
  rot_t [NumWheels:0] rot0;
  cmd_t cmd0;
  assign hd = s_axis_tdata[15:0];

  always_comb begin
    logic [15:0] a;
    for (int l = 0; l <= NumWheels; l++) begin
      a = (l == 0) ? hd : 16'(hd + MountAngle[l-1]);
      rot0[l].flip = (a[15:14] == 2'b01) || (a[15:14] == 2'b10);
      rot0[l].x = CordicX0;
      rot0[l].y = '0;
      rot0[l].z = {{(AngW-32){a[15] ^ rot0[l].flip}}, a[15] ^ rot0[l].flip, a[14:0], 16'd0};
    end
    cmd0.vel_x = s_axis_tdata[31:16];
    cmd0.vel_y = s_axis_tdata[47:32];
    cmd0.turn_rate = s_axis_tdata[63:48];
    cmd0.brake = (s_axis_tdata == 64'd0);
  end

  // chain of cordic cells
  logic v_c [NumStages+1];
  rot_t [NumWheels:0] r_c [NumStages+1];
  cmd_t c_c [NumStages+1];
  assign v_c[0] = s_axis_tvalid;
  assign r_c[0] = rot0;
  assign c_c[0] = cmd0;

  for (genvar i = 0; i < NumStages; i++) begin : g_cell
    obws_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .stage(5'(i)),
      .in_valid(v_c[i]), .in_rot(r_c[i]), .in_cmd(c_c[i]),
      .out_valid(v_c[i+1]), .out_rot(r_c[i+1]), .out_cmd(c_c[i+1])
    );
  end

  // undo the half-turn fold
  logic signed [CordW-1:0] cs [NumWheels+1];
  logic signed [CordW-1:0] sn [NumWheels+1];
  always_comb begin
    for (int l = 0; l <= NumWheels; l++) begin
      cs[l] = r_c[NumStages][l].flip ? -r_c[NumStages][l].x : r_c[NumStages][l].x;
      sn[l] = r_c[NumStages][l].flip ? -r_c[NumStages][l].y : r_c[NumStages][l].y;
    end
  end

  logic signed [15:0] spd [NumWheels];
  for (genvar k = 0; k < NumWheels; k++) begin : g_wheel
    obws_wheel u_wheel (
      .clk(clk), .en(en), .cos_h(cs[0]), .cos_a(cs[k+1]), .sin_a(sn[k+1]),
      .cmd(c_c[NumStages]), .gain(regs[k]), .lever(regs[NumWheels+k]), .speed(spd[k])
    );
  end

  // valid and brake flag travel beside the wheel stages
  logic [TailStages-1:0] tv;
  logic [TailStages-1:0] tb;
  always_ff @(posedge clk) begin
    if (rst) begin
      tv <= '0;
    end else if (en) begin
      tv <= {tv[TailStages-2:0], v_c[NumStages]};
    end
    if (en) tb <= {tb[TailStages-2:0], c_c[NumStages].brake};
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= tv[TailStages-1];
    end
    if (en) begin
      m_axis_tuser <= tb[TailStages-1];
      for (int k = 0; k < NumWheels; k++)
        m_axis_tdata[16*k +: 16] <= tb[TailStages-1] ? 16'd0 : spd[k];
    end
  end

  // a braked result carries zero speeds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 64'd0)
    else $error("braked result with nonzero speed");
  // a held result stays put
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("held result changed");
  // input ready follows the output stall
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready mismatch");

endmodule
`default_nettype wire
